/* hw/rtl/ggs_pkg.sv */
// Package for the gradient guided sweep block.
// Holds register indexes, sweep direction codes and fixed register widths.
// No dependencies.
package ggs_pkg;

    // Configuration port widths.
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int DIR_W        = 2;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Sweep directions.
    localparam logic [DIR_W-1:0] DIR_LEFT_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_TOP_BOTTOM = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT_LEFT = 2'd2;
    localparam logic [DIR_W-1:0] DIR_BOTTOM_TOP = 2'd3;

    // Reset dimensions of the image.
    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 1024;

    // Position flags of one word, carried from the input stage to the blend.
    typedef struct packed {
        logic border;
        logic plane_last;
    } ggs_pos_t;

endpackage

/* hw/rtl/ggs_in_if.sv */
// Input stream channel: a pixel and its gradient per word.
// Depends on nothing.
interface ggs_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pixel_value;
    logic signed [SAMPLE_BITS-1:0] gradient_value;

    modport source (output valid, output pixel_value, output gradient_value, input ready);
    modport sink   (input valid, input pixel_value, input gradient_value, output ready);
endinterface

/* hw/rtl/ggs_out_if.sv */
// Result stream channel: one updated pixel and its end of plane flag per word.
// Depends on nothing.
interface ggs_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] updated_pixel;
    logic                          plane_last;

    modport source (output valid, output updated_pixel, output plane_last, input ready);
    modport sink   (input valid, input updated_pixel, input plane_last, output ready);
endinterface

/* hw/rtl/ggs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module ggs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/ggs_blend.sv */
// Blend of a pixel with its already updated neighbor and a gradient.
// Depends on ggs_pkg.
module ggs_blend #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic [ggs_pkg::DIR_W-1:0]     direction,
    input  ggs_pkg::ggs_pos_t             pos,
    input  logic signed [SAMPLE_BITS-1:0] pixel,
    input  logic signed [SAMPLE_BITS-1:0] gradient,
    input  logic signed [SAMPLE_BITS-1:0] prev_pixel,
    input  logic signed [SAMPLE_BITS-1:0] prev_gradient,
    input  logic signed [SAMPLE_BITS-1:0] line_pixel,
    input  logic signed [SAMPLE_BITS-1:0] line_gradient,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int SW = SAMPLE_BITS + 2;

    logic signed [SW-1:0]          pix_ext;
    logic signed [SW-1:0]          nbr_ext;
    logic signed [SW-1:0]          grd_ext;
    logic signed [SW-1:0]          sum;
    logic signed [SW-1:0]          half;
    logic signed [SAMPLE_BITS-1:0] nbr;
    logic signed [SAMPLE_BITS-1:0] grd;
    logic                          grd_sub;
    logic                          ovf;
    logic signed [SAMPLE_BITS-1:0] clipped;

    // Pick the neighbor and the gradient term for the sweep.
    always_comb
    begin
        case (direction)
            ggs_pkg::DIR_LEFT_RIGHT:
            begin
                nbr     = prev_pixel;
                grd     = prev_gradient;
                grd_sub = 1'b0;
            end
            ggs_pkg::DIR_TOP_BOTTOM:
            begin
                nbr     = line_pixel;
                grd     = line_gradient;
                grd_sub = 1'b0;
            end
            ggs_pkg::DIR_RIGHT_LEFT:
            begin
                nbr     = prev_pixel;
                grd     = gradient;
                grd_sub = 1'b1;
            end
            default:
            begin
                nbr     = line_pixel;
                grd     = gradient;
                grd_sub = 1'b1;
            end
        endcase
    end

    // Three term sum, halved with floor rounding.
    assign pix_ext = {{2{pixel[SAMPLE_BITS-1]}}, pixel};
    assign nbr_ext = {{2{nbr[SAMPLE_BITS-1]}}, nbr};
    assign grd_ext = {{2{grd[SAMPLE_BITS-1]}}, grd};
    assign sum     = grd_sub ? (pix_ext + nbr_ext - grd_ext) : (pix_ext + nbr_ext + grd_ext);
    assign half    = sum >>> 1;

    // Saturate to the sample range; the halved sum fits in one extra bit.
    assign ovf = half[SAMPLE_BITS] != half[SAMPLE_BITS-1];

    always_comb
    begin
        if (!ovf)
        begin
            clipped = half[SAMPLE_BITS-1:0];
        end
        else if (half[SAMPLE_BITS])
        begin
            clipped = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            clipped = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // Border pixels pass through unchanged.
    assign result = pos.border ? pixel : clipped;

endmodule

/* hw/rtl/gradient_guided_sweep.sv */
// Top level of the gradient guided sweep.
// Depends on ggs_pkg, ggs_in_if, ggs_out_if, ggs_ram and ggs_blend.
// Path: an accepted word is registered in the input stage, then in the result register.
// Throughput: one word per cycle unless results stall; prior results feed back from a register.
// The line buffer is one RAM read at acceptance and written when the word leaves the input stage.
// Reset clears position counters, previous result and gradient, and the configuration
// (direction 0, 1024 by 1024); the line buffer holds no reset value and needs no clearing pass.
module gradient_guided_sweep #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ggs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ggs_pkg::CFG_DATA_W-1:0]      cfg_data,
    ggs_in_if.sink                              pixels,
    ggs_out_if.source                           results
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int RW    = 2 * SAMPLE_BITS;

    localparam logic [COL_W-1:0] COL_LAST_RST =
        COL_W'(((ggs_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : ggs_pkg::RESET_WIDTH) - 1);
    localparam logic [ROW_W-1:0] ROW_LAST_RST =
        ROW_W'(((ggs_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : ggs_pkg::RESET_HEIGHT) - 1);

    // Configuration, stored as last column and last row indexes.
    logic [ggs_pkg::DIR_W-1:0]          dir_reg;
    logic [COL_W-1:0]                   col_last_reg;
    logic [ROW_W-1:0]                   row_last_reg;
    logic [ggs_pkg::WIDTH_REG_W-1:0]    cfg_w;
    logic [ggs_pkg::HEIGHT_REG_W-1:0]   cfg_h;
    logic [31:0]                        cfg_w_wide;
    logic [31:0]                        cfg_h_wide;
    logic [COL_W-1:0]                   col_last_next;
    logic [ROW_W-1:0]                   row_last_next;

    // Stream position.
    logic [COL_W-1:0] col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;
    logic             last_col;
    logic             last_row;

    // Input stage.
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_pixel_reg;
    logic signed [SAMPLE_BITS-1:0] s1_grad_reg;
    logic [COL_W-1:0]              s1_idx_reg;
    ggs_pkg::ggs_pos_t             s1_pos_reg;
    ggs_pkg::ggs_pos_t             pos_next;

    // Feedback of the last result.
    logic signed [SAMPLE_BITS-1:0] prev_pixel_reg;
    logic signed [SAMPLE_BITS-1:0] prev_grad_reg;

    // Result register.
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_pixel_reg;
    logic                          out_last_reg;

    logic                          accept;
    logic                          s1_adv;
    logic [RW-1:0]                 line_rd;
    logic signed [SAMPLE_BITS-1:0] blend_y;

    // Handshake: the input stage moves whenever the result register is free or drains.
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || results.ready);
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign accept       = pixels.valid && pixels.ready;

    // Clamp the written dimensions into range and keep the last index.
    assign cfg_w      = cfg_data[ggs_pkg::WIDTH_REG_W-1:0];
    assign cfg_h      = cfg_data[ggs_pkg::HEIGHT_REG_W-1:0];
    assign cfg_w_wide = 32'(cfg_w);
    assign cfg_h_wide = 32'(cfg_h);

    always_comb
    begin
        if (cfg_w_wide == 32'd0)
        begin
            col_last_next = '0;
        end
        else if (cfg_w_wide > 32'(MAX_WIDTH))
        begin
            col_last_next = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last_next = COL_W'(cfg_w_wide - 32'd1);
        end

        if (cfg_h_wide == 32'd0)
        begin
            row_last_next = '0;
        end
        else if (cfg_h_wide > 32'(MAX_HEIGHT))
        begin
            row_last_next = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            row_last_next = ROW_W'(cfg_h_wide - 32'd1);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg      <= ggs_pkg::DIR_LEFT_RIGHT;
            col_last_reg <= COL_LAST_RST;
            row_last_reg <= ROW_LAST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ggs_pkg::REG_DIRECTION:    dir_reg      <= cfg_data[ggs_pkg::DIR_W-1:0];
                ggs_pkg::REG_IMAGE_WIDTH:  col_last_reg <= col_last_next;
                ggs_pkg::REG_IMAGE_HEIGHT: row_last_reg <= row_last_next;
                default:                   ;
            endcase
        end
    end

    // Position of the word being accepted; a count at or past the last index is the last.
    assign last_col          = col_cnt_reg >= col_last_reg;
    assign last_row          = row_cnt_reg >= row_last_reg;
    assign pos_next.border   = (col_cnt_reg == '0) || last_col || (row_cnt_reg == '0) || last_row;
    assign pos_next.plane_last = last_col && last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row ? '0 : row_cnt_reg + 1'b1;
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + 1'b1;
            end
        end
    end

    // Input stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixels.ready)
        begin
            s1_valid_reg <= pixels.valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixels.pixel_value;
            s1_grad_reg  <= pixels.gradient_value;
            s1_idx_reg   <= col_cnt_reg;
            s1_pos_reg   <= pos_next;
        end
    end

    // Line buffer of results and gradients, read for the word being accepted.
    ggs_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_idx_reg),
        .wr_data ({blend_y, s1_grad_reg}),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (line_rd)
    );

    ggs_blend #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_blend (
        .direction     (dir_reg),
        .pos           (s1_pos_reg),
        .pixel         (s1_pixel_reg),
        .gradient      (s1_grad_reg),
        .prev_pixel    (prev_pixel_reg),
        .prev_gradient (prev_grad_reg),
        .line_pixel    (line_rd[RW-1:SAMPLE_BITS]),
        .line_gradient (line_rd[SAMPLE_BITS-1:0]),
        .result        (blend_y)
    );

    // Previous result and gradient, updated as each word leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pixel_reg <= '0;
            prev_grad_reg  <= '0;
        end
        else if (s1_adv)
        begin
            prev_pixel_reg <= blend_y;
            prev_grad_reg  <= s1_grad_reg;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || results.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pixel_reg <= blend_y;
            out_last_reg  <= s1_pos_reg.plane_last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.updated_pixel = out_pixel_reg;
    assign results.plane_last    = out_last_reg;

endmodule
